// File: rtl/core/assert_macros.svh
// assertion helpers used by hsl_checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
		else $error("%m: implication failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("%m: next-cycle implication failed");

`endif

// File: rtl/core/hsl_pkg.sv
package hsl_pkg;

	localparam int DEF_BUCKETS = 4096;
	localparam int DEF_MAX_LEN = 45;
	localparam int DEF_POOL    = 4096;

	localparam int          HASH_W     = 64;
	localparam logic [63:0] HASH_SEED  = 64'd5381;
	localparam int          HASH_SHIFT = 5;

	localparam int POS_W   = 6;
	localparam int CHAR_W  = 8;
	localparam int KIND_W  = 2;
	localparam int STAT_W  = 2;
	localparam int WORDS_W = 13;

	localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CHECK = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_LONG = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_MOD,
		S_HEAD_RD,
		S_HEAD,
		S_NODE_RD,
		S_NODE,
		S_CHR_RD,
		S_CHR,
		S_DONE
	} state_t;

	typedef struct packed {
		logic head_we;
		logic node_we;
		logic char_we;
	} store_ctl_t;

	function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
		if (c >= 8'h41 && c <= 8'h5a) begin
			return c + 8'd32;
		end
		return c;
	endfunction

endpackage

// File: rtl/core/hsl_if.sv
interface hsl_req_if;
	import hsl_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [CHAR_W-1:0]   char_code;
	logic                last_char;

	modport source (output valid, kind, char_code, last_char, input ready);
	modport sink (input valid, kind, char_code, last_char, output ready);
endinterface

interface hsl_rsp_if;
	import hsl_pkg::*;
	logic                valid;
	logic                ready;
	logic                found;
	logic [STAT_W-1:0]   status;
	logic [WORDS_W-1:0]  stored_words;

	modport source (output valid, found, status, stored_words, input ready);
	modport sink (input valid, found, status, stored_words, output ready);
endinterface

// File: rtl/core/hsl_word.sv
module hsl_word
	import hsl_pkg::*;
#(
	parameter int MAX_LEN = DEF_MAX_LEN,
	parameter int IDX_W   = 6
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              clear,
	input  logic [CHAR_W-1:0] char_code,
	output logic [HASH_W-1:0] hash_nx,
	output logic [POS_W-1:0]  pos,
	output logic              overlong,
	input  logic [IDX_W-1:0]  wbuf_raddr,
	output logic [CHAR_W-1:0] wbuf_rdata
);

	logic [HASH_W-1:0] hash_q;
	logic [POS_W-1:0]  pos_q;
	logic              long_q;
	logic              room;
	logic [CHAR_W-1:0] wbuf [MAX_LEN];

	assign room    = pos_q < POS_W'(MAX_LEN);
	assign hash_nx = (hash_q << HASH_SHIFT) + hash_q + HASH_W'(fold_char(char_code));
	assign pos      = pos_q;
	assign overlong = long_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= HASH_SEED;
			pos_q  <= '0;
			long_q <= 1'b0;
		end else if (clear) begin
			hash_q <= HASH_SEED;
			pos_q  <= '0;
			long_q <= 1'b0;
		end else if (push) begin
			hash_q <= hash_nx;
			if (room) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				long_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && room) begin
			wbuf[pos_q[IDX_W-1:0]] <= char_code;
		end
		wbuf_rdata <= wbuf[wbuf_raddr];
	end

endmodule

// File: rtl/core/hsl_mod.sv
module hsl_mod
	import hsl_pkg::*;
#(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int BW      = 12
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] hash_in,
	output logic              done,
	output logic [BW-1:0]     bucket
);

	localparam bit IS_POW2 = (BUCKETS & (BUCKETS - 1)) == 0;

	if (IS_POW2) begin : g_mask
		logic          done_q;
		logic [BW-1:0] bucket_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				bucket_q <= BW'(hash_in & HASH_W'(BUCKETS - 1));
			end
		end

		assign done   = done_q;
		assign bucket = bucket_q;
	end else begin : g_iter
		// restoring remainder, four hash bits per cycle
		logic              busy_q;
		logic              done_q;
		logic [3:0]        cnt_q;
		logic [HASH_W-1:0] sh_q;
		logic [BW-1:0]     rem_q;
		logic [BW+3:0]     r0, r1, r2, r3, r4;

		assign r0 = {rem_q, sh_q[HASH_W-1 -: 4]};
		assign r1 = (r0 >= (BW+4)'(8 * BUCKETS)) ? r0 - (BW+4)'(8 * BUCKETS) : r0;
		assign r2 = (r1 >= (BW+4)'(4 * BUCKETS)) ? r1 - (BW+4)'(4 * BUCKETS) : r1;
		assign r3 = (r2 >= (BW+4)'(2 * BUCKETS)) ? r2 - (BW+4)'(2 * BUCKETS) : r2;
		assign r4 = (r3 >= (BW+4)'(BUCKETS)) ? r3 - (BW+4)'(BUCKETS) : r3;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				busy_q <= 1'b0;
				done_q <= 1'b0;
				cnt_q  <= '0;
			end else begin
				done_q <= 1'b0;
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= '0;
				end else if (busy_q) begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(HASH_W / 4 - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				sh_q  <= hash_in;
				rem_q <= '0;
			end else if (busy_q) begin
				sh_q  <= sh_q << 4;
				rem_q <= BW'(r4);
			end
		end

		assign done   = done_q;
		assign bucket = rem_q;
	end

endmodule

// File: rtl/core/hsl_store.sv
module hsl_store
	import hsl_pkg::*;
#(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int POOL    = DEF_POOL,
	parameter int MAX_LEN = DEF_MAX_LEN,
	parameter int BW      = 12,
	parameter int NW      = 12,
	parameter int LW      = 13,
	parameter int CW      = 18
) (
	input  logic              clk,
	input  store_ctl_t        ctl,
	input  logic [BW-1:0]     head_addr,
	input  logic [LW-1:0]     head_wdata,
	output logic [LW-1:0]     head_rdata,
	input  logic [NW-1:0]     node_addr,
	input  logic [LW-1:0]     node_wlink,
	input  logic [POS_W-1:0]  node_wlen,
	output logic [LW-1:0]     node_rlink,
	output logic [POS_W-1:0]  node_rlen,
	input  logic [CW-1:0]     char_waddr,
	input  logic [CHAR_W-1:0] char_wdata,
	input  logic [CW-1:0]     char_raddr,
	output logic [CHAR_W-1:0] char_rdata
);

	logic [LW-1:0]     heads [BUCKETS];
	logic [LW-1:0]     links [POOL];
	logic [POS_W-1:0]  lens  [POOL];
	logic [CHAR_W-1:0] chars [POOL*MAX_LEN];

	always_ff @(posedge clk) begin
		if (ctl.head_we) begin
			heads[head_addr] <= head_wdata;
		end
		head_rdata <= heads[head_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.node_we) begin
			links[node_addr] <= node_wlink;
			lens[node_addr]  <= node_wlen;
		end
		node_rlink <= links[node_addr];
		node_rlen  <= lens[node_addr];
	end

	always_ff @(posedge clk) begin
		if (ctl.char_we) begin
			chars[char_waddr] <= char_wdata;
		end
		char_rdata <= chars[char_raddr];
	end

endmodule

// File: rtl/core/word_hash_set_lookup.sv
// Word dictionary: a hash set with chained buckets in a fixed node pool. Words come in one
// character per transaction (load or check), or a clear. Characters are taken one per cycle
// while the block is idle; a word's last character starts the bucket computation (a mask
// for a power-of-two bucket count, a remainder otherwise), then a load links its node at the
// head of its bucket chain and a check walks that chain, comparing the characters of each
// node of equal length one by one; each step waits on a registered read of the bucket, node
// or character memory. After reset and after every clear or full-pool load the bucket table
// is swept, during which no transaction is taken. One result per word end or clear.
module word_hash_set_lookup
	import hsl_pkg::*;
#(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int MAX_LEN = DEF_MAX_LEN,
	parameter int POOL    = DEF_POOL
) (
	input  logic       clk,
	input  logic       arst_n,
	hsl_req_if.sink    req,
	hsl_rsp_if.source  rsp
);

	localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int NW    = (POOL > 1) ? $clog2(POOL) : 1;
	localparam int LW    = $clog2(POOL + 1);
	localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CW    = (POOL * MAX_LEN > 1) ? $clog2(POOL * MAX_LEN) : 1;

	state_t state_q, state_nx;

	logic [LW-1:0]     nf_q, total_q, link_q, nlink_q;
	logic [BW-1:0]     clr_cnt_q;
	logic              reply_q;
	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  idx_q;
	logic              res_found_q;
	logic [STAT_W-1:0] res_status_q;

	logic               rsp_valid_q, rsp_found_q;
	logic [STAT_W-1:0]  rsp_status_q;
	logic [WORDS_W-1:0] rsp_words_q;

	logic accept, push, word_end, clear_word, out_free, clr_last, chr_eq, pool_full;

	logic [HASH_W-1:0] hash_nx;
	logic [POS_W-1:0]  pos;
	logic              overlong;
	logic [IDX_W-1:0]  wbuf_raddr;
	logic [CHAR_W-1:0] wbuf_rdata;
	logic              mod_done;
	logic [BW-1:0]     bucket;

	store_ctl_t        ctl;
	logic [BW-1:0]     head_addr;
	logic [LW-1:0]     head_wdata, head_rdata;
	logic [NW-1:0]     node_addr, cur_node;
	logic [LW-1:0]     node_rlink;
	logic [POS_W-1:0]  node_rlen;
	logic [CW-1:0]     char_waddr, char_raddr;
	logic [CHAR_W-1:0] char_rdata;

	assign req.ready  = state_q == S_IDLE;
	assign accept     = req.valid && req.ready;
	assign push       = accept && (req.kind == KIND_LOAD || req.kind == KIND_CHECK);
	assign word_end   = push && req.last_char;
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign clear_word = (accept && req.kind == KIND_CLEAR) || (state_q == S_DONE && out_free);
	assign clr_last   = clr_cnt_q == BW'(BUCKETS - 1);
	assign pool_full  = nf_q >= LW'(POOL);
	assign cur_node   = NW'(link_q - LW'(1));
	assign chr_eq     = fold_char(char_rdata) == fold_char(wbuf_rdata);

	hsl_word #(.MAX_LEN(MAX_LEN), .IDX_W(IDX_W)) u_word (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.clear      (clear_word),
		.char_code  (req.char_code),
		.hash_nx    (hash_nx),
		.pos        (pos),
		.overlong   (overlong),
		.wbuf_raddr (wbuf_raddr),
		.wbuf_rdata (wbuf_rdata)
	);

	hsl_mod #(.BUCKETS(BUCKETS), .BW(BW)) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (word_end),
		.hash_in (hash_nx),
		.done    (mod_done),
		.bucket  (bucket)
	);

	hsl_store #(
		.BUCKETS(BUCKETS), .POOL(POOL), .MAX_LEN(MAX_LEN),
		.BW(BW), .NW(NW), .LW(LW), .CW(CW)
	) u_store (
		.clk        (clk),
		.ctl        (ctl),
		.head_addr  (head_addr),
		.head_wdata (head_wdata),
		.head_rdata (head_rdata),
		.node_addr  (node_addr),
		.node_wlink (head_rdata),
		.node_wlen  (pos),
		.node_rlink (node_rlink),
		.node_rlen  (node_rlen),
		.char_waddr (char_waddr),
		.char_wdata (req.char_code),
		.char_raddr (char_raddr),
		.char_rdata (char_rdata)
	);

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_CLR: begin
				if (clr_last) begin
					state_nx = reply_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept && req.kind == KIND_CLEAR) begin
					state_nx = S_CLR;
				end else if (word_end) begin
					state_nx = S_MOD;
				end
			end
			S_MOD: begin
				if (mod_done) begin
					if (overlong) begin
						state_nx = S_DONE;
					end else if (kind_q == KIND_LOAD && pool_full) begin
						state_nx = S_CLR;
					end else begin
						state_nx = S_HEAD_RD;
					end
				end
			end
			S_HEAD_RD: state_nx = S_HEAD;
			S_HEAD: begin
				if (kind_q == KIND_LOAD || head_rdata == '0) begin
					state_nx = S_DONE;
				end else begin
					state_nx = S_NODE_RD;
				end
			end
			S_NODE_RD: state_nx = S_NODE;
			S_NODE: begin
				if (node_rlen == pos) begin
					state_nx = S_CHR_RD;
				end else if (node_rlink == '0) begin
					state_nx = S_DONE;
				end else begin
					state_nx = S_NODE_RD;
				end
			end
			S_CHR_RD: state_nx = S_CHR;
			S_CHR: begin
				if (!chr_eq) begin
					state_nx = (nlink_q == '0) ? S_DONE : S_NODE_RD;
				end else if (idx_q == POS_W'(pos - POS_W'(1))) begin
					state_nx = S_DONE;
				end else begin
					state_nx = S_CHR_RD;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		ctl.head_we = (state_q == S_CLR) || (state_q == S_HEAD && kind_q == KIND_LOAD);
		ctl.node_we = state_q == S_HEAD && kind_q == KIND_LOAD;
		ctl.char_we = push && pos < POS_W'(MAX_LEN) && !pool_full;
		head_addr   = (state_q == S_CLR) ? clr_cnt_q : bucket;
		head_wdata  = (state_q == S_CLR) ? '0 : LW'(nf_q + LW'(1));
		node_addr   = ctl.node_we ? NW'(nf_q) : cur_node;
		char_waddr  = CW'(32'(nf_q) * 32'(MAX_LEN) + 32'(pos));
		char_raddr  = CW'(32'(cur_node) * 32'(MAX_LEN) + 32'(idx_q));
		wbuf_raddr  = idx_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_cnt_q    <= '0;
			reply_q      <= 1'b0;
			nf_q         <= '0;
			total_q      <= '0;
			kind_q       <= KIND_LOAD;
			link_q       <= '0;
			nlink_q      <= '0;
			idx_q        <= '0;
			res_found_q  <= 1'b0;
			res_status_q <= ST_OK;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= clr_cnt_q + BW'(1);
					if (clr_last) begin
						clr_cnt_q <= '0;
						nf_q      <= '0;
						total_q   <= '0;
					end
				end
				S_IDLE: begin
					if (accept && req.kind == KIND_CLEAR) begin
						reply_q      <= 1'b1;
						res_found_q  <= 1'b0;
						res_status_q <= ST_OK;
					end else if (word_end) begin
						kind_q       <= req.kind;
						res_found_q  <= 1'b0;
						res_status_q <= ST_OK;
					end
				end
				S_MOD: begin
					if (mod_done) begin
						if (overlong) begin
							res_status_q <= ST_LONG;
						end else if (kind_q == KIND_LOAD && pool_full) begin
							res_status_q <= ST_FULL;
							reply_q      <= 1'b1;
						end
					end
				end
				S_HEAD: begin
					if (kind_q == KIND_LOAD) begin
						nf_q    <= nf_q + LW'(1);
						total_q <= total_q + LW'(1);
					end else begin
						link_q <= head_rdata;
					end
				end
				S_NODE: begin
					nlink_q <= node_rlink;
					idx_q   <= '0;
					if (node_rlen != pos) begin
						link_q <= node_rlink;
					end
				end
				S_CHR: begin
					if (!chr_eq) begin
						link_q <= nlink_q;
					end else if (idx_q == POS_W'(pos - POS_W'(1))) begin
						res_found_q <= 1'b1;
					end else begin
						idx_q <= idx_q + POS_W'(1);
					end
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q <= 1'b1;
						reply_q     <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_found_q  <= res_found_q;
			rsp_status_q <= res_status_q;
			rsp_words_q  <= WORDS_W'(total_q);
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.found        = rsp_found_q;
	assign rsp.status       = rsp_status_q;
	assign rsp.stored_words = rsp_words_q;

endmodule

// File: rtl/core/hsl_checker.sv
`include "assert_macros.svh"

module hsl_checker
	import hsl_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic               rsp_found,
	input logic [STAT_W-1:0]  rsp_status,
	input logic [WORDS_W-1:0] rsp_stored_words
);

	`ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)
	`ASSERT_IMPL(a_found_ok, clk, arst_n, rsp_valid && rsp_found, rsp_status == ST_OK)
	`ASSERT_IMPL(a_full_empty, clk, arst_n, rsp_valid && rsp_status == ST_FULL, rsp_stored_words == '0)

endmodule

bind word_hash_set_lookup hsl_checker u_hsl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_found        (rsp.found),
	.rsp_status       (rsp.status),
	.rsp_stored_words (rsp.stored_words)
);

// File: tb/sv/word_hash_set_lookup_checker.sv
`timescale 1ns / 100ps

module word_hash_set_lookup_checker
	import hsl_pkg::*;
#(
	parameter int BUCKETS = DEF_BUCKETS,
	parameter int MAX_LEN = DEF_MAX_LEN,
	parameter int POOL    = DEF_POOL
) (
	input  logic   clk,
	input  logic   arst_n,
	hsl_req_if     req,
	hsl_rsp_if     rsp,
	output int     errors,
	output int     pending
);

	typedef struct packed {
		logic               found;
		logic [STAT_W-1:0]  status;
		logic [WORDS_W-1:0] stored_words;
	} lookup_rsp_t;

	typedef logic [CHAR_W-1:0] word_t [$];

	lookup_rsp_t answers_q [$];
	word_t       dict [$];
	logic [CHAR_W-1:0] cur_word [$];
	logic        too_long;

	function automatic logic [CHAR_W-1:0] lower(input logic [CHAR_W-1:0] c);
		return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
	endfunction

	function automatic logic same_word(input word_t a, input word_t b);
		if (a.size() != b.size())
			return 1'b0;
		foreach (a[i])
			if (lower(a[i]) != lower(b[i]))
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic predict_lookup(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
			input logic lst);
		lookup_rsp_t r;
		r = '0;
		if (k == KIND_CLEAR) begin
			dict.delete();
			cur_word.delete();
			too_long = 1'b0;
			answers_q.push_back(r);
		end else if (k == KIND_LOAD || k == KIND_CHECK) begin
			if (cur_word.size() < MAX_LEN)
				cur_word.push_back(c);
			else
				too_long = 1'b1;
			if (lst) begin
				if (too_long) begin
					r.status = ST_LONG;
				end else if (k == KIND_LOAD) begin
					if (dict.size() >= POOL) begin
						r.status = ST_FULL;
						dict.delete();
					end else begin
						dict.push_back(cur_word);
					end
				end else begin
					foreach (dict[i])
						if (same_word(dict[i], cur_word))
							r.found = 1'b1;
				end
				r.stored_words = WORDS_W'(dict.size());
				answers_q.push_back(r);
				cur_word.delete();
				too_long = 1'b0;
			end
		end
	endtask

	assign pending = answers_q.size();

	always @(posedge clk) begin
		lookup_rsp_t got, want;
		if (!arst_n) begin
			errors = 0;
			too_long = 1'b0;
			dict.delete();
			cur_word.delete();
			answers_q.delete();
		end else begin
			if (req.valid && req.ready)
				predict_lookup(req.kind, req.char_code, req.last_char);
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.found, rsp.status, rsp.stored_words};
				if (answers_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected transaction: expected none, actual %p", $time, got);
				end else begin
					want = answers_q.pop_front();
					if (got.found != want.found) begin
						errors++;
						$display("%0t: found expected %0d actual %0d", $time, want.found,
							got.found);
					end
					if (got.status != want.status) begin
						errors++;
						$display("%0t: status expected %0d actual %0d", $time, want.status,
							got.status);
					end
					if (got.stored_words != want.stored_words) begin
						errors++;
						$display("%0t: stored_words expected %0d actual %0d", $time,
							want.stored_words, got.stored_words);
					end
				end
			end
		end
	end

endmodule

// File: tb/sv/word_hash_set_lookup_tb.sv
`timescale 1ns / 100ps

module word_hash_set_lookup_tb;
	import hsl_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_pct;
	int   sent;

	hsl_req_if req ();
	hsl_rsp_if rsp ();

	word_hash_set_lookup uut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	word_hash_set_lookup_checker chk (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.errors(errors), .pending(pending));

	logic [CHAR_W-1:0] vocab [16][$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("word_hash_set_lookup_tb: done, errors");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= idle_pct);
		end
	end

	task automatic send_char(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] c,
			input logic lst);
		while ($urandom_range(99) < idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.kind      <= k;
		req.char_code <= c;
		req.last_char <= lst;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sent++;
	endtask

	task automatic stop_req();
		req.valid <= 1'b0;
	endtask

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [CHAR_W-1:0] w [$],
			input logic mix_case);
		logic [CHAR_W-1:0] c;
		foreach (w[i]) begin
			c = w[i];
			if (mix_case && c >= 8'h61 && c <= 8'h7a && $urandom_range(1))
				c = c - 8'd32;
			send_char(k, c, i == w.size() - 1);
		end
	endtask

	function automatic void make_word(output logic [CHAR_W-1:0] w [$], input int len,
			input logic any_byte);
		w.delete();
		for (int i = 0; i < len; i++)
			w.push_back(any_byte ? 8'($urandom_range(255)) : 8'($urandom_range(8'h7a, 8'h61)));
	endfunction

	initial begin
		logic [CHAR_W-1:0] w [$];
		int n;
		idle_pct = 21;
		sent = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.kind = KIND_LOAD;
		req.char_code = '0;
		req.last_char = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed
		send_char(KIND_CHECK, 8'h41, 1'b1);
		send_char(KIND_LOAD, 8'h41, 1'b0);
		send_char(KIND_LOAD, 8'h00, 1'b0);
		send_char(KIND_LOAD, 8'hff, 1'b1);
		send_char(KIND_CHECK, 8'h61, 1'b0);
		send_char(KIND_LOAD, 8'h00, 1'b0);
		send_char(KIND_CHECK, 8'hff, 1'b1);
		send_char(KIND_CHECK, 8'h5a, 1'b0);
		send_char(KIND_CHECK, 8'h40, 1'b1);
		send_char(2'd3, 8'h55, 1'b1);
		make_word(w, 46, 1'b0);
		send_word(KIND_LOAD, w, 1'b0);
		w.pop_back();
		send_word(KIND_LOAD, w, 1'b0);
		send_word(KIND_CHECK, w, 1'b1);
		send_char(KIND_LOAD, 8'h7a, 1'b0);
		send_char(KIND_CLEAR, 8'h00, 1'b0);
		send_char(KIND_CHECK, 8'h41, 1'b1);
		stop_req();
		while (pending != 0)
			@(posedge clk);
		// pool-full path with one-character words
		for (int i = 0; i < 4097; i++) begin
			if (i == 200) idle_pct = 0;
			if (i == 1200) idle_pct = 21;
			send_char(KIND_LOAD, 8'($urandom_range(255)), 1'b1);
		end
		send_char(KIND_CHECK, 8'h41, 1'b1);
		// vocabulary words and random traffic
		for (int v = 0; v < 16; v++) begin
			make_word(w, $urandom_range(6, 1), v >= 12);
			vocab[v] = w;
		end
		sent = 0;
		while (sent < 1800) begin
			n = $urandom_range(99);
			if (sent > 600 && sent < 900) idle_pct = 0; else idle_pct = 21;
			if (n < 35) begin
				send_word(KIND_LOAD, vocab[$urandom_range(15)], 1'b1);
			end else if (n < 80) begin
				send_word(KIND_CHECK, vocab[$urandom_range(15)], 1'b1);
			end else if (n < 88) begin
				make_word(w, $urandom_range(8, 1), 1'b1);
				send_word($urandom_range(1) ? KIND_LOAD : KIND_CHECK, w, 1'b0);
			end else if (n < 93) begin
				send_char(2'($urandom_range(3)), 8'($urandom_range(255)),
					1'($urandom_range(1)));
			end else if (n < 95) begin
				send_char(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
			end else if (n < 97) begin
				make_word(w, $urandom_range(50, 44), 1'b0);
				send_word($urandom_range(1) ? KIND_LOAD : KIND_CHECK, w, 1'b1);
			end else begin
				stop_req();
				while (pending != 0)
					@(posedge clk);
			end
		end
		stop_req();
		while (pending != 0)
			@(posedge clk);
		repeat (5000) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("word_hash_set_lookup_tb: done, clean");
		end else begin
			$display("word_hash_set_lookup_tb: done, errors");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/hsl_pkg.sv
rtl/core/hsl_if.sv
rtl/core/hsl_word.sv
rtl/core/hsl_mod.sv
rtl/core/hsl_store.sv
rtl/core/word_hash_set_lookup.sv
rtl/core/hsl_checker.sv
tb/sv/word_hash_set_lookup_checker.sv
tb/sv/word_hash_set_lookup_tb.sv
